>>> design/ostb_pkg.sv
// ----------------------------------------------------------------------------
// ostb_pkg: shared types and constants of the one-shot timer bank
// Operation codes, result codes, the controller state type and the limit on
// expiry beats that one tick may produce.
// ----------------------------------------------------------------------------
`default_nettype none

package ostb_pkg;

	// Operation codes carried on the input tuser.
	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	// Result kind, carried on the output tuser.
	localparam logic KIND_REPLY  = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	// Create reply status.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// Field widths of the stream payloads.
	localparam int SLOT_W  = 4;
	localparam int DELAY_W = 16;
	localparam int CODE_W  = 8;

	// At most this many expiry beats leave for a single tick.
	localparam int MAX_RESULTS = 16;
	localparam int FIRE_BITS   = $clog2(MAX_RESULTS + 1);

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_REPLY,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

`default_nettype wire

>>> design/ostb_slot_ram.sv
// ----------------------------------------------------------------------------
// ostb_slot_ram: slot entry memory
// One write port and one read port with a registered read; the read data
// holds its value while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module ostb_slot_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 40
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/one_shot_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// one_shot_timer_bank_unit: bank of one-shot delay timers
// Slots hold a delay, a running count and an event code; ticks advance the
// counts and slots that reach their delay fire once and are freed.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries the operation on s_tuser and the slot, delay and
// event code on s_tdata. A create beat naming slot 0 claims the lowest free slot,
// any other create claims the named slot, and each answers with one reply beat. A remove beat frees a
// slot and answers nothing. A tick beat walks every slot and sends one
// expiry beat per firing slot; m_tlast marks the final beat of the tick.
// A remove is done when it is accepted. A create of the lowest free slot
// walks the busy flags one slot a cycle. A tick walks the slots through the
// single read port of the slot memory, which delivers one entry a cycle to
// the compare and increment stage while no stall holds the walk. A stalled
// receiver holds up both creates and ticks.
// Reset clears every busy flag, so all slots are free; the slot memory is
// not cleared, an entry is only used while its slot is busy.
// A stalled receiver holds the output register; one further expiry waits in
// a holding register, and the next firing slot stops the walk until the
// output drains. New beats are taken only when the previous one is done.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_bank_unit #(
	parameter int SLOTS      = 16,
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: slot [3:0], delay [19:4], event_code [27:20], zero [31:28]
	input  wire logic [31:0] s_tdata,
	// s_tuser: operation [1:0]
	input  wire logic [1:0]  s_tuser,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// m_tdata: status [0], slot_index [4:1], fired_code [12:5], zero [15:13]
	output logic      [15:0] m_tdata,
	// m_tuser: kind [0]
	output logic             m_tuser,
	output logic             m_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready
);

	import ostb_pkg::*;

	localparam int IDX_BITS   = $clog2(SLOTS);
	localparam int ENTRY_BITS = 2 * COUNT_BITS + CODE_W;

	// Input fields.
	logic [SLOT_W-1:0]  in_slot;
	logic [DELAY_W-1:0] in_delay;
	logic [CODE_W-1:0]  in_code;
	logic               in_accept;

	assign in_slot   = s_tdata[SLOT_W-1:0];
	assign in_delay  = s_tdata[SLOT_W+DELAY_W-1:SLOT_W];
	assign in_code   = s_tdata[SLOT_W+DELAY_W+CODE_W-1:SLOT_W+DELAY_W];
	assign in_accept = s_tvalid && s_tready;

	// Requested slot as a bank index, and whether it lies inside the bank.
	logic [IDX_BITS+SLOT_W-1:0] req_ext;
	logic [IDX_BITS-1:0]        req_idx;
	logic                       req_in_range;
	logic [COUNT_BITS+DELAY_W-1:0] delay_ext;

	assign req_ext      = {{IDX_BITS{1'b0}}, in_slot};
	assign req_idx      = req_ext[IDX_BITS-1:0];
	assign req_in_range = (32'(in_slot) < SLOTS);
	assign delay_ext    = {{COUNT_BITS{1'b0}}, in_delay};

	// Controller and datapath registers.
	state_t                state_q, state_d;
	logic [SLOTS-1:0]      busy_q;
	logic [IDX_BITS-1:0]   find_idx_q;
	logic                  find_ok_q;
	logic [SLOT_W-1:0]     reply_slot_q;
	logic [COUNT_BITS-1:0] new_delay_q;
	logic [CODE_W-1:0]     new_code_q;
	logic [IDX_BITS-1:0]   scan_idx_q;
	logic                  issue_done_q;
	logic                  s1_valid_s1;
	logic [IDX_BITS-1:0]   s1_idx_s1;
	logic [FIRE_BITS-1:0]  fire_cnt_q;
	logic                  pend_valid_q;
	logic [SLOT_W-1:0]     pend_slot_q;
	logic [CODE_W-1:0]     pend_code_q;
	logic                  out_valid_q;
	logic                  out_kind_q;
	logic                  out_status_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [CODE_W-1:0]     out_code_q;
	logic                  out_last_q;

	// Slot memory: {code, count, delay} per slot.
	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic [ENTRY_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [ENTRY_BITS-1:0] ram_rdata;

	ostb_slot_ram #(
		.DEPTH(SLOTS),
		.WIDTH(ENTRY_BITS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_idx_q),
		.rdata(ram_rdata)
	);

	logic [COUNT_BITS-1:0] rd_delay;
	logic [COUNT_BITS-1:0] rd_count;
	logic [CODE_W-1:0]     rd_code;

	assign rd_delay = ram_rdata[COUNT_BITS-1:0];
	assign rd_count = ram_rdata[2*COUNT_BITS-1:COUNT_BITS];
	assign rd_code  = ram_rdata[ENTRY_BITS-1:2*COUNT_BITS];

	// Compare stage of the tick walk.
	logic out_free;
	logic s1_busy;
	logic s1_fire;
	logic s1_inc;
	logic stall;
	logic find_last;
	logic scan_last;
	logic [IDX_BITS+SLOT_W-1:0] find_ext;
	logic [IDX_BITS+SLOT_W-1:0] s1_ext;

	assign out_free  = !out_valid_q || m_tready;
	assign s1_busy   = busy_q[s1_idx_s1];
	assign s1_fire   = s1_valid_s1 && s1_busy && (rd_count == rd_delay)
		&& (fire_cnt_q < FIRE_BITS'(MAX_RESULTS));
	assign s1_inc    = s1_valid_s1 && s1_busy && (rd_count != rd_delay);
	assign stall     = s1_fire && pend_valid_q && !out_free;
	assign find_last = (find_idx_q == IDX_BITS'(SLOTS - 1));
	assign scan_last = (scan_idx_q == IDX_BITS'(SLOTS - 1));
	assign find_ext  = {{SLOT_W{1'b0}}, find_idx_q};
	assign s1_ext    = {{SLOT_W{1'b0}}, s1_idx_s1};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (s_tuser)
						OP_CREATE: state_d = (in_slot == '0) ? ST_FIND : ST_REPLY;
						OP_TICK:   state_d = ST_SCAN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_FIND: begin
				if (!busy_q[find_idx_q] || find_last) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (issue_done_q && !s1_valid_s1) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs: handshake and memory port controls.
	logic load_reply;
	logic push_pend;
	logic flush_pend;
	logic scan_step;

	always_comb begin
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = find_idx_q;
		ram_wdata  = {new_code_q, {COUNT_BITS{1'b0}}, new_delay_q};
		ram_re     = 1'b0;
		load_reply = 1'b0;
		push_pend  = 1'b0;
		flush_pend = 1'b0;
		scan_step  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_REPLY: begin
				if (out_free) begin
					load_reply = 1'b1;
					ram_we     = find_ok_q;
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					scan_step = 1'b1;
					ram_re    = !issue_done_q;
					push_pend = s1_fire && pend_valid_q;
					if (s1_inc) begin
						ram_we    = 1'b1;
						ram_waddr = s1_idx_s1;
						ram_wdata = {rd_code, rd_count + 1'b1, rd_delay};
					end
				end
			end
			ST_FLUSH: begin
				flush_pend = pend_valid_q && out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_q       <= '0;
			find_ok_q    <= 1'b0;
			issue_done_q <= 1'b0;
			s1_valid_s1  <= 1'b0;
			fire_cnt_q   <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// Output register drains on a taken beat and refills from a reply
			// or an expiry.
			out_valid_q <= (out_valid_q && !m_tready) || load_reply || push_pend
				|| flush_pend;

			// Accepted beat.
			if (in_accept) begin
				case (s_tuser)
					OP_CREATE: begin
						find_ok_q <= (in_slot != '0) && req_in_range && !busy_q[req_idx];
					end
					OP_REMOVE: begin
						if (req_in_range) begin
							busy_q[req_idx] <= 1'b0;
						end
					end
					OP_TICK: begin
						issue_done_q <= 1'b0;
						s1_valid_s1  <= 1'b0;
						fire_cnt_q   <= '0;
					end
					default: begin
						find_ok_q <= find_ok_q;
					end
				endcase
			end

			// Lowest free slot search.
			if (state_q == ST_FIND && !busy_q[find_idx_q]) begin
				find_ok_q <= 1'b1;
			end

			// Create claim.
			if (load_reply) begin
				if (find_ok_q) begin
					busy_q[find_idx_q] <= 1'b1;
				end
			end

			// Tick walk: issue reads and evaluate the previous entry.
			if (scan_step) begin
				s1_valid_s1 <= !issue_done_q;
				if (!issue_done_q && scan_last) begin
					issue_done_q <= 1'b1;
				end
				if (s1_fire) begin
					busy_q[s1_idx_s1] <= 1'b0;
					fire_cnt_q        <= fire_cnt_q + 1'b1;
					pend_valid_q      <= 1'b1;
				end
			end

			if (flush_pend) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			new_delay_q  <= delay_ext[COUNT_BITS-1:0];
			new_code_q   <= in_code;
			find_idx_q   <= (in_slot == '0) ? '0 : req_idx;
			reply_slot_q <= in_slot;
			scan_idx_q   <= '0;
		end

		if (state_q == ST_FIND) begin
			if (!busy_q[find_idx_q]) begin
				reply_slot_q <= find_ext[SLOT_W-1:0];
			end else if (find_last) begin
				reply_slot_q <= '0;
			end else begin
				find_idx_q <= find_idx_q + 1'b1;
			end
		end

		if (load_reply) begin
			out_kind_q   <= KIND_REPLY;
			out_status_q <= find_ok_q ? STATUS_OK : STATUS_FAIL;
			out_slot_q   <= reply_slot_q;
			out_code_q   <= '0;
			out_last_q   <= 1'b1;
		end

		if (scan_step) begin
			s1_idx_s1 <= scan_idx_q;
			if (!issue_done_q && !scan_last) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (s1_fire) begin
				pend_slot_q <= s1_ext[SLOT_W-1:0];
				pend_code_q <= rd_code;
			end
		end

		// An earlier expiry moves out when a newer one takes its place; the last one moves out in the flush.
		if (push_pend || flush_pend) begin
			out_kind_q   <= KIND_EXPIRY;
			out_status_q <= STATUS_OK;
			out_slot_q   <= pend_slot_q;
			out_code_q   <= pend_code_q;
			out_last_q   <= flush_pend;
		end
	end

	// Output stream.
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_code_q, out_slot_q, out_status_q};

endmodule

`default_nettype wire
